### design/cphu_pkg.sv
// Shared types and constants for the closest-point-on-hull unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package cphu_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int VIDX_W       = 3;
	localparam int CNT_W        = 4;
	localparam int COORD_W      = 24;
	localparam int DIST_W       = 36;
	localparam int HEAD_W       = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;
	localparam int DIV_STEPS    = 36;
	localparam int DIV_CNT_W    = 6;
	localparam logic [DIST_W-1:0] LIMIT_Q16 = 36'd65536000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HULL_SIZE   = 3'd0,
		REG_CENTER_X    = 3'd1,
		REG_CENTER_Z    = 3'd2,
		REG_HEADING_COS = 3'd3,
		REG_HEADING_SIN = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_FOUND = 2'd0,
		STAT_NONE  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_ROT1, S_ROT2, S_ROT3, S_VA, S_VB, S_D, S_ALONG, S_NORM,
		S_NUM, S_CHK, S_DIV, S_SIGN, S_OFS1, S_OFS2, S_OFS3, S_OFS4, S_E, S_NEXT,
		S_WB1, S_WB2, S_WB3, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_DIFF, OP_ROT1, OP_ROT2, OP_ROT3, OP_VA, OP_VB, OP_D, OP_ALONG,
		OP_NORM, OP_NUM, OP_CHK, OP_DIV, OP_SIGN, OP_OFS1, OP_OFS2, OP_OFS3,
		OP_OFS4, OP_E, OP_WB1, OP_WB2, OP_WB3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [VIDX_W-1:0] raddr;
		logic              latch_query;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             cand_ok;
		logic             out_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

### design/cphu_ctrl.sv
// Sequencer for the hull walk: one datapath op per cycle, held while output stalls.
// Depends on cphu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cphu_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_fire,
	input  wire logic                in_kind,
	input  wire cphu_pkg::dp_stat_t  stat,
	output logic                     in_ready,
	output cphu_pkg::dp_cmd_t        cmd
);

	cphu_pkg::state_t                  state_q, state_nx;
	logic [cphu_pkg::VIDX_W-1:0]       i_q;
	logic [cphu_pkg::DIV_CNT_W-1:0]    div_q;
	logic                              last;
	logic [cphu_pkg::VIDX_W-1:0]       i_next;

	assign last   = ({1'b0, i_q} == (stat.cnt - cphu_pkg::CNT_W'(1)));
	assign i_next = last ? '0 : i_q + cphu_pkg::VIDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cphu_pkg::S_IDLE;
			i_q     <= '0;
			div_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == cphu_pkg::S_IDLE)
				i_q <= '0;
			else if ((state_q == cphu_pkg::S_E || (state_q == cphu_pkg::S_CHK && !stat.cand_ok))
				&& !last)
				i_q <= i_next;
			if (state_q == cphu_pkg::S_DIV)
				div_q <= div_q + cphu_pkg::DIV_CNT_W'(1);
			else
				div_q <= '0;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cphu_pkg::S_IDLE: begin
				if (in_fire && in_kind)
					state_nx = (stat.cnt == '0) ? cphu_pkg::S_DONE : cphu_pkg::S_DIFF;
			end
			cphu_pkg::S_DIFF:  state_nx = cphu_pkg::S_ROT1;
			cphu_pkg::S_ROT1:  state_nx = cphu_pkg::S_ROT2;
			cphu_pkg::S_ROT2:  state_nx = cphu_pkg::S_ROT3;
			cphu_pkg::S_ROT3:  state_nx = cphu_pkg::S_VA;
			cphu_pkg::S_VA:    state_nx = cphu_pkg::S_VB;
			cphu_pkg::S_VB:    state_nx = cphu_pkg::S_D;
			cphu_pkg::S_D:     state_nx = cphu_pkg::S_ALONG;
			cphu_pkg::S_ALONG: state_nx = cphu_pkg::S_NORM;
			cphu_pkg::S_NORM:  state_nx = cphu_pkg::S_NUM;
			cphu_pkg::S_NUM:   state_nx = cphu_pkg::S_CHK;
			cphu_pkg::S_CHK: begin
				if (stat.cand_ok)
					state_nx = cphu_pkg::S_DIV;
				else
					state_nx = last ? cphu_pkg::S_WB1 : cphu_pkg::S_NEXT;
			end
			cphu_pkg::S_DIV: begin
				if (div_q == cphu_pkg::DIV_CNT_W'(cphu_pkg::DIV_STEPS - 1))
					state_nx = cphu_pkg::S_SIGN;
			end
			cphu_pkg::S_SIGN:  state_nx = cphu_pkg::S_OFS1;
			cphu_pkg::S_OFS1:  state_nx = cphu_pkg::S_OFS2;
			cphu_pkg::S_OFS2:  state_nx = cphu_pkg::S_OFS3;
			cphu_pkg::S_OFS3:  state_nx = cphu_pkg::S_OFS4;
			cphu_pkg::S_OFS4:  state_nx = cphu_pkg::S_E;
			cphu_pkg::S_E:     state_nx = last ? cphu_pkg::S_WB1 : cphu_pkg::S_NEXT;
			cphu_pkg::S_NEXT:  state_nx = cphu_pkg::S_VA;
			cphu_pkg::S_WB1:   state_nx = cphu_pkg::S_WB2;
			cphu_pkg::S_WB2:   state_nx = cphu_pkg::S_WB3;
			cphu_pkg::S_WB3:   state_nx = cphu_pkg::S_DONE;
			cphu_pkg::S_DONE: begin
				if (!stat.out_busy)
					state_nx = cphu_pkg::S_IDLE;
			end
			default: state_nx = cphu_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == cphu_pkg::S_IDLE);
		cmd.latch_query = (state_q == cphu_pkg::S_IDLE) && in_fire && in_kind;
		cmd.out_load    = (state_q == cphu_pkg::S_DONE) && !stat.out_busy;
		// the vertex read is registered: address the next vertex in the state before it is needed
		cmd.raddr       = (state_q == cphu_pkg::S_VA) ? i_next : i_q;
		unique case (state_q)
			cphu_pkg::S_DIFF:  cmd.op = cphu_pkg::OP_DIFF;
			cphu_pkg::S_ROT1:  cmd.op = cphu_pkg::OP_ROT1;
			cphu_pkg::S_ROT2:  cmd.op = cphu_pkg::OP_ROT2;
			cphu_pkg::S_ROT3:  cmd.op = cphu_pkg::OP_ROT3;
			cphu_pkg::S_VA:    cmd.op = cphu_pkg::OP_VA;
			cphu_pkg::S_VB:    cmd.op = cphu_pkg::OP_VB;
			cphu_pkg::S_D:     cmd.op = cphu_pkg::OP_D;
			cphu_pkg::S_ALONG: cmd.op = cphu_pkg::OP_ALONG;
			cphu_pkg::S_NORM:  cmd.op = cphu_pkg::OP_NORM;
			cphu_pkg::S_NUM:   cmd.op = cphu_pkg::OP_NUM;
			cphu_pkg::S_CHK:   cmd.op = cphu_pkg::OP_CHK;
			cphu_pkg::S_DIV:   cmd.op = cphu_pkg::OP_DIV;
			cphu_pkg::S_SIGN:  cmd.op = cphu_pkg::OP_SIGN;
			cphu_pkg::S_OFS1:  cmd.op = cphu_pkg::OP_OFS1;
			cphu_pkg::S_OFS2:  cmd.op = cphu_pkg::OP_OFS2;
			cphu_pkg::S_OFS3:  cmd.op = cphu_pkg::OP_OFS3;
			cphu_pkg::S_OFS4:  cmd.op = cphu_pkg::OP_OFS4;
			cphu_pkg::S_E:     cmd.op = cphu_pkg::OP_E;
			cphu_pkg::S_WB1:   cmd.op = cphu_pkg::OP_WB1;
			cphu_pkg::S_WB2:   cmd.op = cphu_pkg::OP_WB2;
			cphu_pkg::S_WB3:   cmd.op = cphu_pkg::OP_WB3;
			default:           cmd.op = cphu_pkg::OP_NOP;
		endcase
	end

endmodule
`default_nettype wire

### design/cphu_dp.sv
// Datapath: configuration, vertex store, two multipliers, serial divider
// and the result register. Depends on cphu_pkg; driven by cphu_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module cphu_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [cphu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cphu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire logic                                 in_fire,
	input  wire logic                                 in_kind,
	input  wire logic [cphu_pkg::VIDX_W-1:0]          in_vidx,
	input  wire logic signed [cphu_pkg::COORD_W-1:0]  in_a,
	input  wire logic signed [cphu_pkg::COORD_W-1:0]  in_b,
	input  wire cphu_pkg::dp_cmd_t                    cmd,
	output cphu_pkg::dp_stat_t                        stat,
	input  wire logic                                 out_ready,
	output logic                                      out_valid,
	output cphu_pkg::status_t                         out_status,
	output logic [cphu_pkg::DIST_W-1:0]               out_dist,
	output logic signed [cphu_pkg::COORD_W-1:0]       out_x,
	output logic signed [cphu_pkg::COORD_W-1:0]       out_z
);

	localparam int CW = cphu_pkg::COORD_W;
	localparam int OW = CW + 1;          // multiplier operand width
	localparam int PW = 2 * OW;          // product width
	localparam int SW = PW + 2;          // product sum width
	localparam int FAR_SH = 20;
	localparam int FRAC_SH = 16;
	localparam int QW = cphu_pkg::DIST_W;
	localparam int SPLIT = 18;

	function automatic logic signed [CW-1:0] sat24(input logic signed [63:0] v);
		logic signed [63:0] hi, lo;
		hi = 64'(2 ** (CW - 1) - 1);
		lo = -64'(2 ** (CW - 1));
		if (v > hi)
			return CW'(hi);
		else if (v < lo)
			return CW'(lo);
		return CW'(v);
	endfunction

	// configuration
	logic [cphu_pkg::CNT_W-1:0]           hull_size_q;
	logic signed [CW-1:0]                 cx_q, cz_q;
	logic signed [cphu_pkg::HEAD_W-1:0]   cos_q, sin_q;

	// vertex store
	logic signed [CW-1:0] vx_mem [cphu_pkg::MAX_VERTICES];
	logic signed [CW-1:0] vy_mem [cphu_pkg::MAX_VERTICES];
	logic signed [CW-1:0] rdx_q, rdy_q;

	// working registers
	logic signed [CW-1:0]     qa_q, qb_q, px0_q, py0_q, ax_q, ay_q, wx_q, wz_q;
	logic signed [OW-1:0]     dx_q, dz_q, tx_q, ty_q, ex_q, ey_q, fx_q, fy_q;
	logic signed [PW-1:0]     pa_q, pb_q, hx_q, hy_q;
	logic signed [SW-1:0]     along_q, norm2_q, num_q;
	logic [QW-1:0]            best_q, quo_q, nsh_q;
	logic [PW-1:0]            rem_q;
	logic                     neg_q, ook_q;
	logic signed [QW:0]       s_q;
	logic signed [47:0]       ox_q, oy_q;

	// multiplier operands
	logic                     mul_en;
	logic signed [OW-1:0]     ma_a, ma_b, mb_a, mb_b;

	logic signed [SW-1:0]     sum_pp, dif_pp;
	logic [SW-1:0]            m_u;
	logic [PW-1:0]            norm_u;
	logic [PW:0]              rem2;
	logic                     div_ge;
	logic signed [OW-1:0]     nx, ny, s_hi, s_lo, ox21, oy21;
	logic signed [63:0]       ox_sum, oy_sum;
	logic [SW-1:0]            best_w;

	assign sum_pp = SW'(pa_q) + SW'(pb_q);
	assign dif_pp = SW'(pa_q) - SW'(pb_q);
	assign m_u    = num_q[SW-1] ? SW'(-num_q) : SW'(num_q);
	assign norm_u = PW'(norm2_q);
	assign rem2   = {rem_q, nsh_q[QW-1]};
	assign div_ge = rem2 >= {1'b0, norm_u};
	assign nx     = -ey_q;
	assign ny     = ex_q;
	assign s_hi   = OW'($signed(s_q[QW:SPLIT]));
	assign s_lo   = OW'({1'b0, s_q[SPLIT-1:0]});
	assign ox21   = OW'($signed(ox_q[FAR_SH:0]));
	assign oy21   = OW'($signed(oy_q[FAR_SH:0]));
	assign ox_sum = (64'(hx_q) <<< SPLIT) + 64'(pa_q);
	assign oy_sum = (64'(hy_q) <<< SPLIT) + 64'(pb_q);
	assign best_w = SW'(best_q);

	assign stat.cnt = (hull_size_q > cphu_pkg::CNT_W'(cphu_pkg::MAX_VERTICES)) ?
		cphu_pkg::CNT_W'(cphu_pkg::MAX_VERTICES) : hull_size_q;
	assign stat.cand_ok = !along_q[SW-1] && (along_q != '0) && (along_q < norm2_q)
		&& ((72'(m_u)) < (72'(norm_u) << FAR_SH));
	assign stat.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hull_size_q <= '0;
			cx_q        <= '0;
			cz_q        <= '0;
			cos_q       <= 16'sd16384;
			sin_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cphu_pkg::REG_HULL_SIZE:   hull_size_q <= cfg_wdata[cphu_pkg::CNT_W-1:0];
				cphu_pkg::REG_CENTER_X:    cx_q <= $signed(cfg_wdata);
				cphu_pkg::REG_CENTER_Z:    cz_q <= $signed(cfg_wdata);
				cphu_pkg::REG_HEADING_COS: cos_q <= $signed(cfg_wdata[cphu_pkg::HEAD_W-1:0]);
				cphu_pkg::REG_HEADING_SIN: sin_q <= $signed(cfg_wdata[cphu_pkg::HEAD_W-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !in_kind) begin
			vx_mem[in_vidx] <= in_a;
			vy_mem[in_vidx] <= in_b;
		end
		rdx_q <= vx_mem[cmd.raddr];
		rdy_q <= vy_mem[cmd.raddr];
	end

	always_comb begin
		mul_en = 1'b1;
		ma_a = '0; ma_b = '0; mb_a = '0; mb_b = '0;
		unique case (cmd.op)
			cphu_pkg::OP_ROT1: begin
				ma_a = dx_q; ma_b = OW'(cos_q); mb_a = dz_q; mb_b = OW'(sin_q);
			end
			cphu_pkg::OP_ROT2: begin
				ma_a = dz_q; ma_b = OW'(cos_q); mb_a = dx_q; mb_b = OW'(sin_q);
			end
			cphu_pkg::OP_VB: begin
				ma_a = tx_q; ma_b = tx_q; mb_a = ty_q; mb_b = ty_q;
			end
			cphu_pkg::OP_D: begin
				ma_a = tx_q; ma_b = ex_q; mb_a = ty_q; mb_b = ey_q;
			end
			cphu_pkg::OP_ALONG: begin
				ma_a = ex_q; ma_b = ex_q; mb_a = ey_q; mb_b = ey_q;
			end
			cphu_pkg::OP_NORM: begin
				ma_a = tx_q; ma_b = ey_q; mb_a = ty_q; mb_b = ex_q;
			end
			cphu_pkg::OP_OFS1: begin
				ma_a = nx; ma_b = s_hi; mb_a = ny; mb_b = s_hi;
			end
			cphu_pkg::OP_OFS2: begin
				ma_a = nx; ma_b = s_lo; mb_a = ny; mb_b = s_lo;
			end
			cphu_pkg::OP_OFS4: begin
				ma_a = ox21; ma_b = ox21; mb_a = oy21; mb_b = oy21;
			end
			cphu_pkg::OP_WB1: begin
				ma_a = fx_q; ma_b = OW'(cos_q); mb_a = fy_q; mb_b = OW'(sin_q);
			end
			cphu_pkg::OP_WB2: begin
				ma_a = fy_q; ma_b = OW'(cos_q); mb_a = fx_q; mb_b = OW'(sin_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			pa_q <= ma_a * ma_b;
			pb_q <= mb_a * mb_b;
		end
		if (cmd.latch_query) begin
			qa_q <= in_a;
			qb_q <= in_b;
		end
		unique case (cmd.op)
			cphu_pkg::OP_DIFF: begin
				dx_q <= OW'(qa_q) - OW'(cx_q);
				dz_q <= OW'(qb_q) - OW'(cz_q);
			end
			cphu_pkg::OP_ROT2: px0_q <= sat24(64'(sum_pp >>> 14));
			cphu_pkg::OP_ROT3: begin
				py0_q  <= sat24(64'(dif_pp >>> 14));
				best_q <= cphu_pkg::LIMIT_Q16;
				fx_q   <= '0;
				fy_q   <= '0;
			end
			cphu_pkg::OP_VA: begin
				ax_q <= rdx_q;
				ay_q <= rdy_q;
				tx_q <= OW'(px0_q) - OW'(rdx_q);
				ty_q <= OW'(py0_q) - OW'(rdy_q);
			end
			cphu_pkg::OP_VB: begin
				ex_q <= OW'(rdx_q) - OW'(ax_q);
				ey_q <= OW'(rdy_q) - OW'(ay_q);
			end
			cphu_pkg::OP_D: begin
				// vertex candidate: strictly smaller wins
				if (sum_pp < $signed(best_w)) begin
					best_q <= QW'(sum_pp);
					fx_q   <= OW'(ax_q);
					fy_q   <= OW'(ay_q);
				end
			end
			cphu_pkg::OP_ALONG: along_q <= sum_pp;
			cphu_pkg::OP_NORM:  norm2_q <= sum_pp;
			cphu_pkg::OP_NUM:   num_q   <= dif_pp;
			cphu_pkg::OP_CHK: begin
				rem_q <= PW'(m_u >> FAR_SH);
				nsh_q <= {m_u[FAR_SH-1:0], FRAC_SH'(0)};
				quo_q <= '0;
				neg_q <= num_q[SW-1];
			end
			cphu_pkg::OP_DIV: begin
				rem_q <= div_ge ? PW'(rem2 - {1'b0, norm_u}) : PW'(rem2);
				quo_q <= {quo_q[QW-2:0], div_ge};
				nsh_q <= {nsh_q[QW-2:0], 1'b0};
			end
			cphu_pkg::OP_SIGN: s_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			cphu_pkg::OP_OFS2: begin
				hx_q <= pa_q;
				hy_q <= pb_q;
			end
			cphu_pkg::OP_OFS3: begin
				ox_q <= 48'(ox_sum >>> FRAC_SH);
				oy_q <= 48'(oy_sum >>> FRAC_SH);
			end
			cphu_pkg::OP_OFS4: begin
				ook_q <= (ox_q > -48'sd1048576) && (ox_q < 48'sd1048576)
					&& (oy_q > -48'sd1048576) && (oy_q < 48'sd1048576);
			end
			cphu_pkg::OP_E: begin
				if (ook_q && (sum_pp < $signed(best_w))) begin
					best_q <= QW'(sum_pp);
					fx_q   <= OW'(px0_q) + ox21;
					fy_q   <= OW'(py0_q) + oy21;
				end
			end
			cphu_pkg::OP_WB2: wx_q <= sat24(64'(dif_pp >>> 14) + 64'(cx_q));
			cphu_pkg::OP_WB3: wz_q <= sat24(64'(sum_pp >>> 14) + 64'(cz_q));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.out_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (stat.cnt == '0) begin
				out_status <= cphu_pkg::STAT_EMPTY;
				out_dist   <= '0;
				out_x      <= '0;
				out_z      <= '0;
			end else if (best_q < cphu_pkg::LIMIT_Q16) begin
				out_status <= cphu_pkg::STAT_FOUND;
				out_dist   <= best_q;
				out_x      <= wx_q;
				out_z      <= wz_q;
			end else begin
				out_status <= cphu_pkg::STAT_NONE;
				out_dist   <= cphu_pkg::LIMIT_Q16;
				out_x      <= '0;
				out_z      <= '0;
			end
		end
	end

endmodule
`default_nettype wire

### design/closest_point_on_convex_hull_unit.sv
// Closest point on a convex hull: top level joining sequencer and datapath.
// Depends on cphu_pkg, cphu_ctrl and cphu_dp.
//
// Usage:
//   Configure hull_size, center and heading through cfg_we/cfg_index/cfg_wdata
//   while the block is idle. Input requests on s_*: s_tuser = 0 loads a hull
//   vertex (no result), s_tuser = 1 runs a query on a world point. Each query
//   returns one result on m_*: status in m_tuser, distance and point in m_tdata.
//   A load is written as it is accepted. A query first moves the point into
//   the hull frame, then walks each hull edge, running the 36-step serial
//   divider when the perpendicular foot is a candidate, then returns to the
//   world frame and loads the output. An empty hull goes straight to the load.
//   One query is worked on at a time; s_tready is high only while idle.
//   The result sits in an output register; a stalled receiver holds it, and the
//   block still takes loads and a following query, holding the next result
//   until the register frees.
//   Reset clears configuration to its defaults and empties the output; the
//   vertex store is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_convex_hull_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // vertex_index[2:0], coord_a[26:3], coord_b[50:27]
	input  wire logic        s_tuser,  // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,  // dist_sq[35:0], found_x[59:36], found_z[83:60]
	output logic [1:0]       m_tuser   // status
);

	logic                         in_fire;
	cphu_pkg::dp_cmd_t            cmd;
	cphu_pkg::dp_stat_t           stat;
	cphu_pkg::status_t            res_status;
	logic [cphu_pkg::DIST_W-1:0]  res_dist;
	logic signed [23:0]           res_x, res_z;

	assign in_fire = s_tvalid && s_tready;

	cphu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_kind  (s_tuser),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	cphu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_fire    (in_fire),
		.in_kind    (s_tuser),
		.in_vidx    (s_tdata[2:0]),
		.in_a       ($signed(s_tdata[26:3])),
		.in_b       ($signed(s_tdata[50:27])),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (res_status),
		.out_dist   (res_dist),
		.out_x      (res_x),
		.out_z      (res_z)
	);

	assign m_tuser = res_status;
	assign m_tdata = {4'd0, res_z, res_x, res_dist};

endmodule
`default_nettype wire

### design/cphu_checker.sv
// Port-level checks for closest_point_on_convex_hull_unit, bound to the top.
// Depends on cphu_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module cphu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [87:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == cphu_pkg::STAT_FOUND || m_tuser == cphu_pkg::STAT_NONE
			|| m_tuser == cphu_pkg::STAT_EMPTY))
		else $error("bad status code");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cphu_pkg::STAT_EMPTY |-> m_tdata == '0)
		else $error("empty hull result not zero");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cphu_pkg::STAT_NONE |->
			m_tdata[35:0] == cphu_pkg::LIMIT_Q16 && m_tdata[83:36] == '0)
		else $error("no-hit result malformed");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cphu_pkg::STAT_FOUND |-> m_tdata[35:0] < cphu_pkg::LIMIT_Q16)
		else $error("found distance not below limit");

endmodule

bind closest_point_on_convex_hull_unit cphu_checker u_cphu_checker (.*);
`default_nettype wire
